// ===== hdl/htcal_pkg.sv =====
// Package for the humidity/temperature two-point calibration block.
// Register indexes, sample kinds, status codes, field widths and pipeline depths.
// No dependencies.
package htcal_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_HUM_REF0_X2  = 3'd0,
		REG_HUM_REF1_X2  = 3'd1,
		REG_HUM_RAW0     = 3'd2,
		REG_HUM_RAW1     = 3'd3,
		REG_TEMP_REF0_X8 = 3'd4,
		REG_TEMP_REF1_X8 = 3'd5,
		REG_TEMP_RAW0    = 3'd6,
		REG_TEMP_RAW1    = 3'd7
	} reg_idx_t;

	// Sample kind
	localparam logic KIND_HUM  = 1'b0;
	localparam logic KIND_TEMP = 1'b1;

	// Result status
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_SPAN = 2'd1,
		ST_CLAMPED   = 2'd2
	} status_t;

	// Field widths
	localparam int RawW     = 16;
	localparam int HumRefW  = 8;
	localparam int TempRefW = 10;
	localparam int CfgW     = 16;
	localparam int HumW     = 7;
	localparam int TempW    = 16;
	localparam int InDataW  = 16;
	localparam int OutDataW = 32;

	// Output constants
	localparam logic [HumW-1:0]  HumMax  = 7'd100;
	localparam logic [TempW-1:0] TempMax = 16'h7FFF;
	localparam logic [TempW-1:0] TempMin = 16'h8000;

	// Divider: 16 quotient bits, two per stage
	localparam int QuoW       = 16;
	localparam int BitsPerStg = 2;
	localparam int DivStages  = QuoW / BitsPerStg;
	localparam int StDiv0     = 6;
	localparam int NumStages  = StDiv0 + DivStages;

	// Side band that rides along the divider stages
	typedef struct packed {
		logic kind;
		logic neg;
		logic zspan;
		logic ovf;
	} ctl_t;

endpackage

// ===== hdl/humidity_temperature_calibration_top.sv =====
// Two-point linear calibration of humidity / temperature samples, fully pipelined.
// Holds the calibration registers, a 14-stage datapath and a restoring divider.
// Depends on htcal_pkg.
//
// Channel      Dir  Handshake               Payload
// s_axis       in   tvalid/tready           tdata: raw_count[15:0]; tuser: kind
// m_axis       out  tvalid/tready           tdata: humidity_pct, temperature_q8, status
// cfg          in   cfg_we (no wait)        cfg_addr: register index, cfg_data: value
//
// One transaction per cycle is sustained while m_axis_tready is held high.
// The depth is set by the 16-bit quotient, retired two bits per stage in
// eight divider stages after five setup stages.
// Each stage has its own valid bit and advances when empty or when the next
// stage moves, so bubbles collapse during an output stall and nothing is lost.
// arst_n clears the calibration registers and all valid bits.
module humidity_temperature_calibration_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_addr,
	input  logic [htcal_pkg::CfgW-1:0]      cfg_data,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [htcal_pkg::InDataW-1:0]   s_axis_tdata,  // [15:0] raw_count
	input  logic                            s_axis_tuser,  // [0] kind
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [htcal_pkg::OutDataW-1:0]  m_axis_tdata,  // [6:0] humidity_pct,
	                                                        // [22:7] temperature_q8,
	                                                        // [24:23] status, rest 0
	output logic                            m_axis_tuser   // [0] kind_out
);

	localparam int NS = htcal_pkg::NumStages;
	localparam int DS = htcal_pkg::DivStages;
	localparam int QW = htcal_pkg::QuoW;

	// ---------------- calibration registers ----------------
	logic [htcal_pkg::HumRefW-1:0]  hum_ref0_q, hum_ref1_q;
	logic [htcal_pkg::RawW-1:0]     hum_raw0_q, hum_raw1_q;
	logic [htcal_pkg::TempRefW-1:0] temp_ref0_q, temp_ref1_q;
	logic [htcal_pkg::RawW-1:0]     temp_raw0_q, temp_raw1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hum_ref0_q  <= '0;
			hum_ref1_q  <= '0;
			hum_raw0_q  <= '0;
			hum_raw1_q  <= '0;
			temp_ref0_q <= '0;
			temp_ref1_q <= '0;
			temp_raw0_q <= '0;
			temp_raw1_q <= '0;
		end else if (cfg_we) begin
			unique case (htcal_pkg::reg_idx_t'(cfg_addr))
				htcal_pkg::REG_HUM_REF0_X2:  hum_ref0_q  <= cfg_data[htcal_pkg::HumRefW-1:0];
				htcal_pkg::REG_HUM_REF1_X2:  hum_ref1_q  <= cfg_data[htcal_pkg::HumRefW-1:0];
				htcal_pkg::REG_HUM_RAW0:     hum_raw0_q  <= cfg_data;
				htcal_pkg::REG_HUM_RAW1:     hum_raw1_q  <= cfg_data;
				htcal_pkg::REG_TEMP_REF0_X8: temp_ref0_q <= cfg_data[htcal_pkg::TempRefW-1:0];
				htcal_pkg::REG_TEMP_REF1_X8: temp_ref1_q <= cfg_data[htcal_pkg::TempRefW-1:0];
				htcal_pkg::REG_TEMP_RAW0:    temp_raw0_q <= cfg_data;
				htcal_pkg::REG_TEMP_RAW1:    temp_raw1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- pipeline flow control ----------------
	// vld_s[k] is the valid bit of stage k; en[k] lets stage k load.
	logic [NS:1] vld_s;
	logic [NS:1] en;

	always_comb begin
		en[NS] = !vld_s[NS] || m_axis_tready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= (k == 1) ? s_axis_tvalid : vld_s[(k > 1) ? k - 1 : 1];
				end
			end
		end
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = vld_s[NS];

	// ---------------- stage 1: pick calibration set, differences ----------------
	logic [9:0] sel_r0, sel_r1;
	logic [15:0] sel_c0, sel_c1;

	always_comb begin
		if (s_axis_tuser == htcal_pkg::KIND_TEMP) begin
			sel_r0 = temp_ref0_q;
			sel_r1 = temp_ref1_q;
			sel_c0 = temp_raw0_q;
			sel_c1 = temp_raw1_q;
		end else begin
			sel_r0 = {2'b00, hum_ref0_q};
			sel_r1 = {2'b00, hum_ref1_q};
			sel_c0 = hum_raw0_q;
			sel_c1 = hum_raw1_q;
		end
	end

	logic               kind_s1;
	logic signed [16:0] diff_s1;   // raw - c0
	logic signed [10:0] dref_s1;   // ref1 - ref0
	logic [9:0]         r0_s1;
	logic signed [16:0] den_s1;    // c1 - c0

	always_ff @(posedge clk) begin
		if (en[1]) begin
			kind_s1 <= s_axis_tuser;
			diff_s1 <= $signed({s_axis_tdata[15], s_axis_tdata}) - $signed({sel_c0[15], sel_c0});
			dref_s1 <= $signed({1'b0, sel_r1}) - $signed({1'b0, sel_r0});
			r0_s1   <= sel_r0;
			den_s1  <= $signed({sel_c1[15], sel_c1}) - $signed({sel_c0[15], sel_c0});
		end
	end

	// ---------------- stage 2: the two products ----------------
	logic               kind_s2;
	logic signed [27:0] p1_s2, p2_s2;
	logic signed [16:0] den_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			kind_s2 <= kind_s1;
			p1_s2   <= diff_s1 * dref_s1;
			p2_s2   <= $signed({1'b0, r0_s1}) * den_s1;
			den_s2  <= den_s1;
		end
	end

	// ---------------- stage 3: numerator sum ----------------
	logic               kind_s3;
	logic signed [28:0] sum_s3;
	logic signed [16:0] den_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			kind_s3 <= kind_s2;
			sum_s3  <= $signed({p1_s2[27], p1_s2}) + $signed({p2_s2[27], p2_s2});
			den_s3  <= den_s2;
		end
	end

	// ---------------- stage 4: magnitudes and sign of the quotient ----------------
	logic [28:0] sum_neg, sum_abs;
	logic [16:0] den_neg, den_abs;

	always_comb begin
		sum_neg = 29'(-sum_s3);
		den_neg = 17'(-den_s3);
		sum_abs = sum_s3[28] ? sum_neg : sum_s3;
		den_abs = den_s3[16] ? den_neg : den_s3;
	end

	logic        kind_s4, neg_s4, zspan_s4;
	logic [26:0] mag_s4;    // |numerator| stays below 2^27
	logic [15:0] dabs_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			kind_s4  <= kind_s3;
			neg_s4   <= (sum_s3 != '0) && (sum_s3[28] != den_s3[16]);
			zspan_s4 <= (den_s3 == '0);
			mag_s4   <= sum_abs[26:0];
			dabs_s4  <= den_abs[15:0];
		end
	end

	// ---------------- stage 5: scale, overflow check, divider seed ----------------
	// Temperature is 32x the numerator. If the upper half of the dividend is
	// already >= divisor the quotient needs more than 16 bits: saturate.
	logic [31:0] dvd;

	always_comb begin
		if (kind_s4 == htcal_pkg::KIND_TEMP) begin
			dvd = {mag_s4, 5'b00000};
		end else begin
			dvd = {5'b00000, mag_s4};
		end
	end

	htcal_pkg::ctl_t ctl_s5;
	logic [15:0]     rem_s5, lo_s5, dabs_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ctl_s5.kind  <= kind_s4;
			ctl_s5.neg   <= neg_s4;
			ctl_s5.zspan <= zspan_s4;
			ctl_s5.ovf   <= (dvd[31:16] >= dabs_s4);
			rem_s5       <= (dvd[31:16] >= dabs_s4) ? 16'd0 : dvd[31:16];
			lo_s5        <= dvd[15:0];
			dabs_s5      <= dabs_s4;
		end
	end

	// ---------------- stages 6..13: restoring divider ----------------
	// lo holds the unshifted dividend bits on top and the quotient bits below.
	htcal_pkg::ctl_t ctl_sd  [DS];
	logic [15:0]     rem_sd  [DS];
	logic [QW-1:0]   lo_sd   [DS];
	logic [15:0]     dabs_sd [DS];

	for (genvar j = 0; j < DS; j++) begin : g_div
		htcal_pkg::ctl_t ctl_in;
		logic [15:0]     rem_in, dabs_in, rem_nx;
		logic [QW-1:0]   lo_in, lo_nx;

		if (j == 0) begin : g_first
			assign ctl_in  = ctl_s5;
			assign rem_in  = rem_s5;
			assign lo_in   = lo_s5;
			assign dabs_in = dabs_s5;
		end else begin : g_next
			assign ctl_in  = ctl_sd[j-1];
			assign rem_in  = rem_sd[j-1];
			assign lo_in   = lo_sd[j-1];
			assign dabs_in = dabs_sd[j-1];
		end

		always_comb begin
			logic [16:0] t;
			logic [16:0] d;
			rem_nx = rem_in;
			lo_nx  = lo_in;
			for (int b = 0; b < htcal_pkg::BitsPerStg; b++) begin
				t     = {rem_nx, lo_nx[QW-1]};
				lo_nx = {lo_nx[QW-2:0], 1'b0};
				d     = t - {1'b0, dabs_in};
				if (t >= {1'b0, dabs_in}) begin
					rem_nx   = d[15:0];
					lo_nx[0] = 1'b1;
				end else begin
					rem_nx = t[15:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[htcal_pkg::StDiv0 + j]) begin
				ctl_sd[j]  <= ctl_in;
				rem_sd[j]  <= rem_nx;
				lo_sd[j]   <= lo_nx;
				dabs_sd[j] <= dabs_in;
			end
		end
	end

	// ---------------- stage 14: clamp, sign, status (output register) ----------------
	htcal_pkg::ctl_t ctl_f;
	logic [QW-1:0]   quo;
	logic [14:0]     hq;
	logic [htcal_pkg::HumW-1:0]  hum_nx;
	logic [htcal_pkg::TempW-1:0] temp_nx;
	htcal_pkg::status_t          st_nx;

	assign ctl_f = ctl_sd[DS-1];
	assign quo   = lo_sd[DS-1];
	assign hq    = quo[QW-1:1];   // humidity divides by twice the span

	always_comb begin
		hum_nx  = '0;
		temp_nx = '0;
		st_nx   = htcal_pkg::ST_OK;
		priority if (ctl_f.zspan) begin
			st_nx = htcal_pkg::ST_ZERO_SPAN;
		end else if (ctl_f.kind == htcal_pkg::KIND_HUM) begin
			priority if (ctl_f.neg) begin
				st_nx = htcal_pkg::ST_CLAMPED;
			end else if (ctl_f.ovf || hq > 15'(htcal_pkg::HumMax)) begin
				hum_nx = htcal_pkg::HumMax;
				st_nx  = htcal_pkg::ST_CLAMPED;
			end else begin
				hum_nx = hq[htcal_pkg::HumW-1:0];
			end
		end else begin
			priority if (!ctl_f.neg && (ctl_f.ovf || quo[QW-1])) begin
				temp_nx = htcal_pkg::TempMax;
				st_nx   = htcal_pkg::ST_CLAMPED;
			end else if (ctl_f.neg && (ctl_f.ovf || quo > htcal_pkg::TempMin)) begin
				temp_nx = htcal_pkg::TempMin;
				st_nx   = htcal_pkg::ST_CLAMPED;
			end else if (ctl_f.neg) begin
				temp_nx = 16'(~quo + 16'd1);
			end else begin
				temp_nx = quo;
			end
		end
	end

	logic                        kind_s14;
	logic [htcal_pkg::HumW-1:0]  hum_s14;
	logic [htcal_pkg::TempW-1:0] temp_s14;
	htcal_pkg::status_t          status_s14;

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			kind_s14   <= ctl_f.kind;
			hum_s14    <= hum_nx;
			temp_s14   <= temp_nx;
			status_s14 <= st_nx;
		end
	end

	assign m_axis_tuser = kind_s14;
	assign m_axis_tdata = {7'b0000000, status_s14, temp_s14, hum_s14};

endmodule

// ===== tb/htcal_checker.sv =====
// Scoreboard for the humidity/temperature calibration block: tracks register writes,
// predicts one result per accepted sample and compares it with the result stream.
// Depends on htcal_pkg.
module htcal_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_addr,
	input  logic [htcal_pkg::CfgW-1:0]      cfg_data,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [htcal_pkg::InDataW-1:0]   s_axis_tdata,   // [15:0] raw_count
	input  logic                            s_axis_tuser,   // [0] kind
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [htcal_pkg::OutDataW-1:0]  m_axis_tdata,   // [6:0] humidity_pct,
	                                                         // [22:7] temperature_q8,
	                                                         // [24:23] status
	input  logic                            m_axis_tuser,   // [0] kind_out
	output int                              fail_count,
	output int                              outstanding,
	output int                              checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                        kind;
		logic [htcal_pkg::HumW-1:0]  hum;
		logic [htcal_pkg::TempW-1:0] temp;
		htcal_pkg::status_t          status;
	} cal_result_t;

	// local copy of the calibration registers
	logic [htcal_pkg::HumRefW-1:0]      hum_ref0, hum_ref1;
	logic signed [htcal_pkg::RawW-1:0]  hum_raw0, hum_raw1;
	logic [htcal_pkg::TempRefW-1:0]     temp_ref0, temp_ref1;
	logic signed [htcal_pkg::RawW-1:0]  temp_raw0, temp_raw1;

	cal_result_t expected_q[$];

	initial begin
		fail_count  = 0;
		outstanding = 0;
		checked     = 0;
	end

	// exact two-point interpolation, truncated, then clamped per kind
	function automatic cal_result_t calibrate(input logic kind,
		input logic [htcal_pkg::RawW-1:0] raw_bits);
		cal_result_t r;
		longint raw, r0, r1, c0, c1, span, num, q;
		r.kind   = kind;
		r.hum    = '0;
		r.temp   = '0;
		r.status = htcal_pkg::ST_OK;
		raw = longint'($signed(raw_bits));
		if (kind == htcal_pkg::KIND_HUM) begin
			r0 = longint'(hum_ref0);
			r1 = longint'(hum_ref1);
			c0 = longint'(hum_raw0);
			c1 = longint'(hum_raw1);
		end else begin
			r0 = longint'(temp_ref0);
			r1 = longint'(temp_ref1);
			c0 = longint'(temp_raw0);
			c1 = longint'(temp_raw1);
		end
		span = c1 - c0;
		if (span == 0) begin
			r.status = htcal_pkg::ST_ZERO_SPAN;
		end else if (kind == htcal_pkg::KIND_HUM) begin
			num = (raw - c0) * (r1 - r0) + r0 * span;
			if (span < 0) begin
				span = -span;
				num  = -num;
			end
			if (num < 0) begin
				r.status = htcal_pkg::ST_CLAMPED;
			end else begin
				q = num / (2 * span);
				if (q > 100) begin
					r.hum    = htcal_pkg::HumMax;
					r.status = htcal_pkg::ST_CLAMPED;
				end else begin
					r.hum = q[htcal_pkg::HumW-1:0];
				end
			end
		end else begin
			num = 32 * ((raw - c0) * (r1 - r0) + r0 * span);
			q = num / span;
			if (q > 32767) begin
				q = 32767;
				r.status = htcal_pkg::ST_CLAMPED;
			end else if (q < -32768) begin
				q = -32768;
				r.status = htcal_pkg::ST_CLAMPED;
			end
			r.temp = q[htcal_pkg::TempW-1:0];
		end
		return r;
	endfunction

	task automatic check_field(input string name, input longint expv, input longint actv);
		if (expv != actv) begin
			$error("%s mismatch: expected %0d, got %0d", name, expv, actv);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		cal_result_t want;
		if (!arst_n) begin
			hum_ref0  = '0;
			hum_ref1  = '0;
			hum_raw0  = '0;
			hum_raw1  = '0;
			temp_ref0 = '0;
			temp_ref1 = '0;
			temp_raw0 = '0;
			temp_raw1 = '0;
			expected_q.delete();
			outstanding = 0;
		end else begin
			// result side first so a result can never match the sample of the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					$error("result transaction with no sample pending: tdata %h tuser %b",
						m_axis_tdata, m_axis_tuser);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("kind_out", want.kind, m_axis_tuser);
					check_field("humidity_pct", want.hum, m_axis_tdata[6:0]);
					check_field("temperature_q8", longint'($signed(want.temp)),
						longint'($signed(m_axis_tdata[22:7])));
					check_field("status", want.status, m_axis_tdata[24:23]);
					check_field("tdata padding", 0,
						m_axis_tdata[htcal_pkg::OutDataW-1:25]);
					checked++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(calibrate(s_axis_tuser, s_axis_tdata));
			if (cfg_we) begin
				case (htcal_pkg::reg_idx_t'(cfg_addr))
					htcal_pkg::REG_HUM_REF0_X2:
						hum_ref0  = cfg_data[htcal_pkg::HumRefW-1:0];
					htcal_pkg::REG_HUM_REF1_X2:
						hum_ref1  = cfg_data[htcal_pkg::HumRefW-1:0];
					htcal_pkg::REG_HUM_RAW0:
						hum_raw0  = cfg_data[htcal_pkg::RawW-1:0];
					htcal_pkg::REG_HUM_RAW1:
						hum_raw1  = cfg_data[htcal_pkg::RawW-1:0];
					htcal_pkg::REG_TEMP_REF0_X8:
						temp_ref0 = cfg_data[htcal_pkg::TempRefW-1:0];
					htcal_pkg::REG_TEMP_REF1_X8:
						temp_ref1 = cfg_data[htcal_pkg::TempRefW-1:0];
					htcal_pkg::REG_TEMP_RAW0:
						temp_raw0 = cfg_data[htcal_pkg::RawW-1:0];
					htcal_pkg::REG_TEMP_RAW1:
						temp_raw1 = cfg_data[htcal_pkg::RawW-1:0];
					default: ;
				endcase
			end
			outstanding = expected_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top for humidity_temperature_calibration_top: clock, reset, stimulus and verdict.
// Prediction and comparison live in htcal_checker; depends on htcal_pkg and the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit  = 400000;  // far above the slowest legal run
	localparam int PhaseCount  = 12;
	localparam int PhaseItems  = 140;
	localparam int LongHold    = 160;     // result side back-pressure, in cycles

	typedef logic [htcal_pkg::CfgW-1:0] word_t;
	typedef logic [htcal_pkg::RawW-1:0] raw_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [2:0]                     cfg_addr;
	logic [htcal_pkg::CfgW-1:0]     cfg_data;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [htcal_pkg::InDataW-1:0]  s_axis_tdata;   // [15:0] raw_count
	logic                           s_axis_tuser;   // [0] kind
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [htcal_pkg::OutDataW-1:0] m_axis_tdata;   // [6:0] humidity_pct, [22:7] temperature_q8,
	                                                 // [24:23] status
	logic                           m_axis_tuser;   // [0] kind_out

	int fail_count, outstanding, checked;
	int cycles;
	int samples_sent;
	int settings_used;

	// quiet: neither side idles; hold_off: sink makes a single long stall (LongHold)
	bit quiet;
	bit hold_off;

	// words last written to the register file, indexed by register
	word_t cal_words [8];

	humidity_temperature_calibration_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	htcal_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.checked       (checked)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("[humidity_temperature_calibration_top] ERROR");
			$finish;
		end
	end

	// Result sink. Each iteration owns one result transaction: optional stall, then
	// tready high until the transaction happens. All changes at the falling edge.
	initial begin : result_sink
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				stall = LongHold;
			end else begin
				stall = quiet ? 0 : int'($urandom_range(0, 3));
			end
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	// One sample transaction. Called and returns at a falling edge; tvalid stays high
	// after acceptance so back-to-back samples never drop it.
	task automatic send_sample(input logic kind, input raw_t raw);
		int gap;
		gap = quiet ? 0 : int'($urandom_range(0, 3));
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= raw;
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
		@(negedge clk);
	endtask

	// Stop offering, wait for every pending result, then let the pipeline go idle.
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (htcal_pkg::NumStages + 2) @(negedge clk);
	endtask

	// Write all eight registers from cal_words, one per cycle; block must be idle.
	task automatic program_cal();
		for (int i = 0; i < 8; i++) begin
			cfg_we   <= 1'b1;
			cfg_addr <= htcal_pkg::reg_idx_t'(i);
			cfg_data <= cal_words[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Reference point, biased toward the ends; unused upper data bits get noise
	function automatic word_t ref_word(input int w);
		word_t v, noise;
		noise = word_t'($urandom);
		case ($urandom_range(0, 3))
			0:       v = '0;
			1:       v = word_t'((1 << w) - 1);
			default: v = word_t'($urandom_range(0, (1 << w) - 1));
		endcase
		return v | (noise & ~word_t'((1 << w) - 1));
	endfunction

	// Pair of raw calibration counts: full-scale ends, a narrow span, or anything
	task automatic pick_raw_pair(output raw_t a, output raw_t b);
		int base, v;
		case ($urandom_range(0, 3))
			0: begin
				a = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				b = $urandom_range(0, 1) ? ~a : raw_t'($urandom);
			end
			1: begin
				base = int'($signed(raw_t'($urandom)));
				v = base + int'($urandom_range(0, 128)) - 64;
				if (v > 32767) v = 32767;
				if (v < -32768) v = -32768;
				a = base[htcal_pkg::RawW-1:0];
				b = v[htcal_pkg::RawW-1:0];
			end
			default: begin
				a = raw_t'($urandom);
				b = raw_t'($urandom);
			end
		endcase
	endtask

	// Raw sample: mostly around the calibrated span so that in-range results dominate
	function automatic raw_t pick_raw(input logic kind);
		int a, b, lo, span, v;
		if (kind == htcal_pkg::KIND_HUM) begin
			a = int'($signed(cal_words[htcal_pkg::REG_HUM_RAW0]));
			b = int'($signed(cal_words[htcal_pkg::REG_HUM_RAW1]));
		end else begin
			a = int'($signed(cal_words[htcal_pkg::REG_TEMP_RAW0]));
			b = int'($signed(cal_words[htcal_pkg::REG_TEMP_RAW1]));
		end
		if ($urandom_range(0, 3) == 0)
			return raw_t'($urandom);
		lo   = (a < b) ? a : b;
		span = (a < b) ? b - a : a - b;
		v = lo - span - 1 + int'($urandom_range(0, 3 * span + 2));
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[htcal_pkg::RawW-1:0];
	endfunction

	task automatic randomize_cal(input int phase);
		raw_t a, b;
		cal_words[htcal_pkg::REG_HUM_REF0_X2]  = ref_word(htcal_pkg::HumRefW);
		cal_words[htcal_pkg::REG_HUM_REF1_X2]  = ref_word(htcal_pkg::HumRefW);
		cal_words[htcal_pkg::REG_TEMP_REF0_X8] = ref_word(htcal_pkg::TempRefW);
		cal_words[htcal_pkg::REG_TEMP_REF1_X8] = ref_word(htcal_pkg::TempRefW);
		pick_raw_pair(a, b);
		cal_words[htcal_pkg::REG_HUM_RAW0] = a;
		cal_words[htcal_pkg::REG_HUM_RAW1] = b;
		pick_raw_pair(a, b);
		cal_words[htcal_pkg::REG_TEMP_RAW0] = a;
		cal_words[htcal_pkg::REG_TEMP_RAW1] = b;
		// one setting each with a collapsed span for one of the kinds
		if (phase == 9)
			cal_words[htcal_pkg::REG_HUM_RAW1] = cal_words[htcal_pkg::REG_HUM_RAW0];
		if (phase == 10)
			cal_words[htcal_pkg::REG_TEMP_RAW1] = cal_words[htcal_pkg::REG_TEMP_RAW0];
	endtask

	initial begin : stimulus
		logic k;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = htcal_pkg::KIND_HUM;
		quiet         = 1'b0;
		hold_off      = 1'b0;
		samples_sent  = 0;
		settings_used = 0;
		foreach (cal_words[i]) cal_words[i] = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed part ---
		// registers at reset value: both kinds see a zero span
		send_sample(htcal_pkg::KIND_HUM, 16'h1234);
		send_sample(htcal_pkg::KIND_TEMP, 16'h8000);
		quiesce();

		// ordinary calibration: 20..80 %RH over -1000..1000, 25..85 degC over -2000..3000
		cal_words[htcal_pkg::REG_HUM_REF0_X2]  = 16'd40;
		cal_words[htcal_pkg::REG_HUM_REF1_X2]  = 16'd160;
		cal_words[htcal_pkg::REG_HUM_RAW0]     = 16'(-1000);
		cal_words[htcal_pkg::REG_HUM_RAW1]     = 16'd1000;
		cal_words[htcal_pkg::REG_TEMP_REF0_X8] = 16'd200;
		cal_words[htcal_pkg::REG_TEMP_REF1_X8] = 16'd680;
		cal_words[htcal_pkg::REG_TEMP_RAW0]    = 16'(-2000);
		cal_words[htcal_pkg::REG_TEMP_RAW1]    = 16'd3000;
		program_cal();
		send_sample(htcal_pkg::KIND_HUM, 16'h8000);      // below zero percent
		send_sample(htcal_pkg::KIND_HUM, 16'h7FFF);      // above 100 percent
		send_sample(htcal_pkg::KIND_HUM, 16'd0);
		send_sample(htcal_pkg::KIND_HUM, 16'(-1000));
		send_sample(htcal_pkg::KIND_HUM, 16'd1000);
		send_sample(htcal_pkg::KIND_HUM, 16'd1);
		send_sample(htcal_pkg::KIND_TEMP, 16'h8000);     // saturates low
		send_sample(htcal_pkg::KIND_TEMP, 16'h7FFF);     // saturates high
		send_sample(htcal_pkg::KIND_TEMP, 16'd0);
		send_sample(htcal_pkg::KIND_TEMP, 16'(-2000));
		send_sample(htcal_pkg::KIND_TEMP, 16'd3000);
		send_sample(htcal_pkg::KIND_TEMP, 16'hFFFF);
		quiesce();

		// register extremes, falling references and a negative span for humidity
		cal_words[htcal_pkg::REG_HUM_REF0_X2]  = 16'd255;
		cal_words[htcal_pkg::REG_HUM_REF1_X2]  = 16'd0;
		cal_words[htcal_pkg::REG_HUM_RAW0]     = 16'h7FFF;
		cal_words[htcal_pkg::REG_HUM_RAW1]     = 16'h8000;
		cal_words[htcal_pkg::REG_TEMP_REF0_X8] = 16'd1023;
		cal_words[htcal_pkg::REG_TEMP_REF1_X8] = 16'd0;
		cal_words[htcal_pkg::REG_TEMP_RAW0]    = 16'h8000;
		cal_words[htcal_pkg::REG_TEMP_RAW1]    = 16'h7FFF;
		program_cal();
		send_sample(htcal_pkg::KIND_HUM, 16'h7FFF);
		send_sample(htcal_pkg::KIND_HUM, 16'h8000);
		send_sample(htcal_pkg::KIND_HUM, 16'd0);
		send_sample(htcal_pkg::KIND_TEMP, 16'h8000);
		send_sample(htcal_pkg::KIND_TEMP, 16'h7FFF);
		send_sample(htcal_pkg::KIND_TEMP, 16'd0);
		quiesce();

		// --- random part: a fresh calibration per phase ---
		for (int p = 0; p < PhaseCount; p++) begin
			randomize_cal(p);
			program_cal();
			// phase 4 runs without gaps and with one long result stall to fill the pipe
			quiet = (p % 3 == 1) || (p == 4);
			for (int i = 0; i < PhaseItems; i++) begin
				if (p == 4 && i == 20)
					hold_off = 1'b1;
				if (p == 7 && i == PhaseItems / 2)
					quiesce();  // sender stops until every result is back
				k = 1'($urandom_range(0, 1));
				send_sample(k, pick_raw(k));
			end
			quiesce();
		end

		$display("Sent %0d samples across %0d calibration settings; %0d results compared.",
			samples_sent, settings_used, checked);
		if (fail_count == 0 && outstanding == 0)
			$display("[humidity_temperature_calibration_top] OK");
		else
			$display("[humidity_temperature_calibration_top] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/htcal_pkg.sv
hdl/humidity_temperature_calibration_top.sv
tb/htcal_checker.sv
tb/tb.sv
